// ----- src/gfi_pkg.sv -----
// Shared types and constants for the grid field interpolator.
// Holds table sizing, field widths, register and command codes and the sequencer states.
// No dependencies.
package gfi_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SEG_W       = 8;
    localparam int FRAC_W      = 16;
    localparam int QUOT_W      = SEG_W + FRAC_W;
    localparam int NUM_W       = DATA_WIDTH + SEG_W;
    localparam int DIFF_W      = DATA_WIDTH + 1;
    localparam int MUL_A_W     = DATA_WIDTH + 2;
    localparam int MUL_B_W     = FRAC_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SUM_W       = DATA_WIDTH + 3;
    localparam int DIV_CNT_W   = $clog2(QUOT_W + 1);

    localparam int S_TDATA_W   = 8 + 2 * DATA_WIDTH;
    localparam int M_TDATA_W   = DATA_WIDTH + SEG_W;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]     ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [DATA_WIDTH-1:0] DOMAIN_LOW_RST  = '0;
    localparam logic signed [DATA_WIDTH-1:0] DOMAIN_HIGH_RST = DATA_WIDTH'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIFORM  = 3'd0,
        CFG_VERTICES = 3'd1,
        CFG_DLOW     = 3'd2,
        CFG_DHIGH    = 3'd3,
        CFG_SEGS     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_UMUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_SRCH,
        ST_SRCH_DONE,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_WAIT,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_OUT
    } state_t;

endpackage

// ----- src/grid_field_interpolator.sv -----
// Grid field interpolator: a load transfer (tuser 0) writes one position/value entry; a query
// transfer (tuser 1) returns the field value and lower entry index at a Q16.16 coordinate. The
// block takes one query at a time and is not ready while it works. A query at or beyond the
// domain ends goes from classify straight to the table reads and the output step. On a uniform
// grid the 24 steps of the shared restoring divider find segment and fraction together. On a
// stored-position grid the search reads one stored position per cycle from the table memory,
// then, when interpolating, 16 divider steps give the fraction.
// Interpolation uses one shared multiplier.
// A finished result waits in the output register while the next transfer is accepted.
// Depends on gfi_pkg.
module grid_field_interpolator
    import gfi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index, coordinate, sample_value
    input  logic [0:0]            s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // field_value, segment_found
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    state_t state_reg, state_next;

    // configuration
    logic                         uniform_reg;
    logic                         vav_reg;
    logic signed [DATA_WIDTH-1:0] dlow_reg;
    logic signed [DATA_WIDTH-1:0] dhigh_reg;
    logic [SEG_W-1:0]             segcnt_reg;

    // tables
    logic signed [DATA_WIDTH-1:0] pos_mem [TABLE_DEPTH];
    logic signed [DATA_WIDTH-1:0] val_mem [TABLE_DEPTH];
    logic signed [DATA_WIDTH-1:0] pos_rdata_reg;
    logic signed [DATA_WIDTH-1:0] val_rdata_reg;
    logic [ADDR_W-1:0]            rd_addr;

    // datapath
    logic signed [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0]        off_reg, off_next;
    logic [DATA_WIDTH-1:0]        den_reg, den_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic [DATA_WIDTH-1:0]        rem_reg, rem_next;
    logic [QUOT_W-1:0]            low_reg, low_next;
    logic [QUOT_W-1:0]            quot_reg, quot_next;
    logic [DIV_CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]             scan_reg, scan_next;
    logic                         have_reg, have_next;
    logic signed [DATA_WIDTH-1:0] prev_pos_reg, prev_pos_next;
    logic signed [DATA_WIDTH-1:0] hi_pos_reg, hi_pos_next;
    logic [CNT_W-1:0]             hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0]            lo_idx_reg, lo_idx_next;
    logic                         lerp_reg, lerp_next;
    logic [FRAC_W-1:0]            f_reg, f_next;
    logic signed [DATA_WIDTH-1:0] vm_reg, vm_next;
    logic signed [DIFF_W-1:0]     diff_reg, diff_next;
    logic signed [DATA_WIDTH-1:0] res_reg, res_next;
    logic signed [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    logic [SEG_W-1:0]             out_found_reg, out_found_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    // input unpacking
    logic                         in_cmd;
    logic [ADDR_W-1:0]            in_index;
    logic signed [DATA_WIDTH-1:0] in_coord;
    logic signed [DATA_WIDTH-1:0] in_sample;
    logic                         s_accept;

    // derived values
    logic [SEG_W-1:0]             seg_eff;
    logic [CNT_W-1:0]             lim;
    logic [ADDR_W-1:0]            last_idx;
    logic                         x_le_low;
    logic                         x_ge_high;
    logic                         pos_hit;
    logic                         out_free;

    // shared divider step
    logic [DIFF_W-1:0]            trial;
    logic [DIFF_W-1:0]            trial_sub;
    logic                         trial_ge;

    // shared multiplier and rounding
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic signed [PROD_W-1:0]     prod_rnd;
    logic signed [SUM_W-1:0]      lerp_sum;
    logic signed [DATA_WIDTH-1:0] lerp_sat;

    assign in_cmd    = s_tuser[0];
    assign in_index  = s_tdata[ADDR_W-1:0];
    assign in_coord  = s_tdata[8+DATA_WIDTH-1:8];
    assign in_sample = s_tdata[8+2*DATA_WIDTH-1:8+DATA_WIDTH];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {out_found_reg, out_value_reg};

    assign seg_eff   = (segcnt_reg == '0) ? SEG_W'(1) : segcnt_reg;
    assign lim       = CNT_W'(seg_eff) + CNT_W'(vav_reg);
    assign last_idx  = vav_reg ? ADDR_W'(seg_eff) : ADDR_W'(seg_eff - SEG_W'(1));
    assign x_le_low  = (x_reg <= dlow_reg);
    assign x_ge_high = (x_reg >= dhigh_reg);
    assign pos_hit   = have_reg && (x_reg < pos_rdata_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign trial     = {rem_reg, low_reg[QUOT_W-1]};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    assign mul_a = (state_reg == ST_UMUL) ? MUL_A_W'({2'b00, off_reg})
                                          : MUL_A_W'({diff_reg[DIFF_W-1], diff_reg});
    assign mul_b = (state_reg == ST_UMUL) ? MUL_B_W'(seg_eff) : MUL_B_W'({1'b0, f_reg});
    assign mul_p = mul_a * mul_b;

    assign prod_rnd = prod_reg + ROUND_HALF;
    assign lerp_sum = SUM_W'(prod_rnd >>> FRAC_W) + SUM_W'(vm_reg);

    always_comb begin
        if (lerp_sum > SUM_W'(DMAX)) begin
            lerp_sat = DMAX;
        end else if (lerp_sum < SUM_W'(DMIN)) begin
            lerp_sat = DMIN;
        end else begin
            lerp_sat = lerp_sum[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        case (state_reg)
            ST_SRCH:  rd_addr = scan_reg[ADDR_W-1:0];
            ST_RD_HI: rd_addr = lo_idx_reg + ADDR_W'(1);
            default:  rd_addr = lo_idx_reg;
        endcase
    end

    // table memories: write on load transfers, registered read
    always_ff @(posedge aclk) begin
        if (s_accept && in_cmd == CMD_LOAD) begin
            pos_mem[in_index] <= in_coord;
            val_mem[in_index] <= in_sample;
        end
        pos_rdata_reg <= pos_mem[rd_addr];
        val_rdata_reg <= val_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uniform_reg <= 1'b1;
            vav_reg     <= 1'b1;
            dlow_reg    <= DOMAIN_LOW_RST;
            dhigh_reg   <= DOMAIN_HIGH_RST;
            segcnt_reg  <= SEG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_UNIFORM:  uniform_reg <= cfg_data[0];
                CFG_VERTICES: vav_reg     <= cfg_data[0];
                CFG_DLOW:     dlow_reg    <= cfg_data;
                CFG_DHIGH:    dhigh_reg   <= cfg_data;
                CFG_SEGS:     segcnt_reg  <= cfg_data[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_cmd == CMD_QUERY) begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (x_le_low || x_ge_high) begin
                    state_next = ST_RD_LO;
                end else if (uniform_reg) begin
                    state_next = ST_UMUL;
                end else begin
                    state_next = ST_SRCH;
                end
            end
            ST_UMUL:     state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:  state_next = ST_RD_LO;
            ST_SRCH: begin
                if (pos_hit || scan_reg == lim) begin
                    state_next = ST_SRCH_DONE;
                end
            end
            ST_SRCH_DONE: begin
                if (hit_idx_reg != '0 && hit_idx_reg != lim && vav_reg) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_RD_LO;
                end
            end
            ST_RD_LO:    state_next = ST_RD_HI;
            ST_RD_HI:    state_next = lerp_reg ? ST_RD_WAIT : ST_OUT;
            ST_RD_WAIT:  state_next = ST_LERP_MUL;
            ST_LERP_MUL: state_next = ST_LERP_ADD;
            ST_LERP_ADD: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and output register updates
    always_comb begin
        x_next         = x_reg;
        off_next       = off_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        have_next      = have_reg;
        prev_pos_next  = prev_pos_reg;
        hi_pos_next    = hi_pos_reg;
        hit_idx_next   = hit_idx_reg;
        lo_idx_next    = lo_idx_reg;
        lerp_next      = lerp_reg;
        f_next         = f_reg;
        vm_next        = vm_reg;
        diff_next      = diff_reg;
        res_next       = res_reg;
        out_value_next = out_value_reg;
        out_found_next = out_found_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_cmd == CMD_QUERY) begin
                    x_next = in_coord;
                end
            end
            ST_CLASSIFY: begin
                lerp_next = 1'b0;
                if (x_le_low) begin
                    lo_idx_next = '0;
                end else if (x_ge_high) begin
                    lo_idx_next = last_idx;
                end else if (uniform_reg) begin
                    off_next  = DATA_WIDTH'(x_reg - dlow_reg);
                    den_next  = DATA_WIDTH'(dhigh_reg - dlow_reg);
                    lerp_next = vav_reg;
                end else begin
                    scan_next = '0;
                    have_next = 1'b0;
                end
            end
            ST_UMUL: begin
                prod_next = mul_p;
            end
            ST_DIV_LOAD: begin
                // quotient of offset * segments / span: segment in top bits, fraction below
                rem_next  = prod_reg[NUM_W-1:SEG_W];
                low_next  = {prod_reg[SEG_W-1:0], {FRAC_W{1'b0}}};
                quot_next = '0;
                cnt_next  = DIV_CNT_W'(QUOT_W);
            end
            ST_DIV: begin
                rem_next  = trial_ge ? trial_sub[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                low_next  = {low_reg[QUOT_W-2:0], 1'b0};
                quot_next = {quot_reg[QUOT_W-2:0], trial_ge};
                cnt_next  = cnt_reg - DIV_CNT_W'(1);
            end
            ST_DIV_END: begin
                f_next = quot_reg[FRAC_W-1:0];
                if (uniform_reg) begin
                    lo_idx_next = ADDR_W'(quot_reg[QUOT_W-1:FRAC_W]);
                end
            end
            ST_SRCH: begin
                // compare the position read last cycle while the next read goes out
                if (pos_hit) begin
                    hit_idx_next = scan_reg - CNT_W'(1);
                    hi_pos_next  = pos_rdata_reg;
                end else if (scan_reg == lim) begin
                    hit_idx_next = lim;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                    have_next = 1'b1;
                    if (have_reg) begin
                        prev_pos_next = pos_rdata_reg;
                    end
                end
            end
            ST_SRCH_DONE: begin
                lerp_next = 1'b0;
                if (hit_idx_reg == '0) begin
                    lo_idx_next = '0;
                end else if (hit_idx_reg == lim) begin
                    lo_idx_next = last_idx;
                end else begin
                    lo_idx_next = ADDR_W'(hit_idx_reg - CNT_W'(1));
                    if (vav_reg) begin
                        lerp_next = 1'b1;
                        den_next  = DATA_WIDTH'(hi_pos_reg - prev_pos_reg);
                        rem_next  = DATA_WIDTH'(x_reg - prev_pos_reg);
                        low_next  = '0;
                        quot_next = '0;
                        cnt_next  = DIV_CNT_W'(FRAC_W);
                    end
                end
            end
            ST_RD_LO: ;
            ST_RD_HI: begin
                vm_next  = val_rdata_reg;
                res_next = val_rdata_reg;
            end
            ST_RD_WAIT: begin
                diff_next = DIFF_W'(val_rdata_reg) - DIFF_W'(vm_reg);
            end
            ST_LERP_MUL: begin
                prod_next = mul_p;
            end
            ST_LERP_ADD: begin
                res_next = lerp_sat;
            end
            ST_OUT: begin
                if (out_free) begin
                    out_value_next = res_reg;
                    out_found_next = SEG_W'(lo_idx_reg);
                    m_tvalid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        off_reg       <= off_next;
        den_reg       <= den_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        low_reg       <= low_next;
        quot_reg      <= quot_next;
        cnt_reg       <= cnt_next;
        scan_reg      <= scan_next;
        have_reg      <= have_next;
        prev_pos_reg  <= prev_pos_next;
        hi_pos_reg    <= hi_pos_next;
        hit_idx_reg   <= hit_idx_next;
        lo_idx_reg    <= lo_idx_next;
        lerp_reg      <= lerp_next;
        f_reg         <= f_next;
        vm_reg        <= vm_next;
        diff_reg      <= diff_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        out_found_reg <= out_found_next;
    end

    // the divider only works on a proper remainder
    a_div_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH) |-> (scan_reg <= lim))
        else $error("search ran past the entries in use");

    a_upper_entry_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_HI && lerp_reg) |-> (lo_idx_reg != '1))
        else $error("upper interpolation entry wrapped");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

endmodule

// ----- tb/sv/tb_grid_field_interpolator.sv -----
// Self-checking bench for the grid field interpolator: table loads, uniform and stored-position
// lookups, vertex and per-segment values, under several idling patterns. Depends on gfi_pkg and
// grid_field_interpolator; the expected field values are worked out by the class below.
`timescale 1ns / 100ps

module tb_grid_field_interpolator;
    import gfi_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam longint ONE       = 65536;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic [SEG_W-1:0]             seg;
    } field_point_t;

    // Predicts the field value of each query and matches it against the result stream.
    class field_scoreboard;
        logic signed [DATA_WIDTH-1:0] value_tbl [TABLE_DEPTH];
        logic signed [DATA_WIDTH-1:0] position_tbl [TABLE_DEPTH];
        bit                           grid_uniform;
        bit                           vertex_mode;
        logic signed [DATA_WIDTH-1:0] dom_lo;
        logic signed [DATA_WIDTH-1:0] dom_hi;
        logic [SEG_W-1:0]             seg_cnt;
        field_point_t                 awaited [$];
        int                           failures;

        function new();
            foreach (value_tbl[k]) begin
                value_tbl[k]    = '0;
                position_tbl[k] = '0;
            end
            grid_uniform = 1'b1;
            vertex_mode  = 1'b1;
            dom_lo       = DOMAIN_LOW_RST;
            dom_hi       = DOMAIN_HIGH_RST;
            seg_cnt      = 8'd1;
            failures     = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [DATA_WIDTH-1:0] data);
            case (idx)
                CFG_UNIFORM:  grid_uniform = data[0];
                CFG_VERTICES: vertex_mode  = data[0];
                CFG_DLOW:     dom_lo       = data;
                CFG_DHIGH:    dom_hi       = data;
                CFG_SEGS:     seg_cnt      = data[SEG_W-1:0];
                default: ;
            endcase
        endfunction

        function int segments();
            return (seg_cnt == 0) ? 1 : int'(seg_cnt);
        endfunction

        // Index of the last entry in use, held inside the table.
        function int last_entry();
            int n;
            n = segments() + (vertex_mode ? 1 : 0);
            return (n > TABLE_DEPTH) ? TABLE_DEPTH - 1 : n - 1;
        endfunction

        // Linear blend with a 16-bit fraction, halves rounded up, saturated.
        function longint blend(longint v_lo, longint v_hi, longint frac);
            longint diff;
            longint whole;
            longint part;
            longint sum;
            diff  = v_hi - v_lo;
            whole = diff >>> FRAC_W;
            part  = diff & 64'hFFFF;
            sum   = v_lo + whole * frac + ((part * frac + 32768) >>> FRAC_W);
            if (sum > longint'(DMAX)) return longint'(DMAX);
            if (sum < longint'(DMIN)) return longint'(DMIN);
            return sum;
        endfunction

        function field_point_t lookup(logic signed [DATA_WIDTH-1:0] x);
            field_point_t r;
            longint       xs;
            longint       span;
            longint       num;
            longint       quot;
            longint       frac;
            longint       base;
            int           top;
            int           i;
            xs  = x;
            top = last_entry();
            if (xs <= longint'(dom_lo)) begin
                r.value = value_tbl[0];
                r.seg   = '0;
            end else if (xs >= longint'(dom_hi)) begin
                r.value = value_tbl[top];
                r.seg   = SEG_W'(top);
            end else if (grid_uniform) begin
                span = longint'(dom_hi) - longint'(dom_lo);
                num  = (xs - longint'(dom_lo)) * segments();
                quot = num / span;
                frac = ((num - quot * span) <<< FRAC_W) / span;
                r.seg = SEG_W'(quot);
                if (vertex_mode)
                    r.value = DATA_WIDTH'(blend(value_tbl[quot], value_tbl[quot + 1], frac));
                else
                    r.value = value_tbl[quot];
            end else begin
                i = 0;
                while (i <= top && xs >= longint'(position_tbl[i]))
                    i++;
                if (i == 0) begin
                    r.value = value_tbl[0];
                    r.seg   = '0;
                end else if (i > top) begin
                    r.value = value_tbl[top];
                    r.seg   = SEG_W'(top);
                end else begin
                    r.seg = SEG_W'(i - 1);
                    if (vertex_mode) begin
                        base = position_tbl[i - 1];
                        frac = ((xs - base) <<< FRAC_W) / (longint'(position_tbl[i]) - base);
                        r.value = DATA_WIDTH'(blend(value_tbl[i - 1], value_tbl[i], frac));
                    end else begin
                        r.value = value_tbl[i - 1];
                    end
                end
            end
            return r;
        endfunction

        function void note_item(logic cmd, logic [7:0] idx, logic signed [DATA_WIDTH-1:0] coord,
                                logic signed [DATA_WIDTH-1:0] sample);
            if (cmd == CMD_LOAD) begin
                position_tbl[idx] = coord;
                value_tbl[idx]    = sample;
            end else begin
                awaited = {awaited, lookup(coord)};
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            field_point_t want;
            if (awaited.size() == 0) begin
                $error("result with no query outstanding: field_value %0d segment_found %0d",
                       $signed(data[DATA_WIDTH-1:0]), data[M_TDATA_W-1:DATA_WIDTH]);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if ($signed(data[DATA_WIDTH-1:0]) != want.value) begin
                $error("field_value mismatch: expected %0d, got %0d",
                       want.value, $signed(data[DATA_WIDTH-1:0]));
                failures++;
            end
            if (data[M_TDATA_W-1:DATA_WIDTH] != want.seg) begin
                $error("segment_found mismatch: expected %0d, got %0d",
                       want.seg, data[M_TDATA_W-1:DATA_WIDTH]);
                failures++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // entry_index, coordinate, sample_value
    logic [0:0]            s_tuser;    // command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // field_value, segment_found
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [DATA_WIDTH-1:0] cfg_data;

    field_scoreboard sb = new();
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_request       = 1'b0;
    int cycle_count        = 0;

    grid_field_interpolator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Uniform pick in [a, b] after clamping both ends to the data range.
    function automatic logic signed [DATA_WIDTH-1:0] rand_between(longint a, longint b);
        longint unsigned span;
        longint unsigned r;
        if (a < longint'(DMIN)) a = longint'(DMIN);
        if (b > longint'(DMAX)) b = longint'(DMAX);
        if (b <= a) return DATA_WIDTH'(a);
        span = longint'(b - a) + 1;
        r    = {$urandom, $urandom};
        return DATA_WIDTH'(a + longint'(r % span));
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return DMIN;
        if (pick == 1) return DMAX;
        return $urandom;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_coord();
        int     pick;
        int     top;
        longint lo;
        longint hi;
        pick = $urandom_range(99);
        top  = sb.last_entry();
        if (sb.grid_uniform || sb.position_tbl[top] <= sb.position_tbl[0]) begin
            lo = sb.dom_lo;
            hi = sb.dom_hi;
        end else begin
            lo = longint'(sb.position_tbl[0]) - ONE;
            hi = longint'(sb.position_tbl[top]) + ONE;
        end
        if (pick < 60) return rand_between(lo + 1, hi - 1);
        if (pick < 68) return sb.position_tbl[$urandom_range(top)];
        if (pick < 78) begin
            case ($urandom_range(3))
                0: return sb.dom_lo;
                1: return sb.dom_hi;
                2: return sb.dom_lo + 1;
                default: return sb.dom_hi - 1;
            endcase
        end
        if (pick < 88) return $urandom_range(1) ? DMAX : DMIN;
        return $urandom;
    endfunction

    task automatic send_item(logic cmd, logic [7:0] idx, logic signed [DATA_WIDTH-1:0] coord,
                             logic signed [DATA_WIDTH-1:0] sample);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {sample, coord, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(cmd, idx, coord, sample);
        @(negedge aclk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // Hold the input until every outstanding query has returned.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.awaited.size() != 0);
    endtask

    task automatic apply_settings(bit uniform, bit vertices, longint lo, longint hi, int segs);
        drain();
        // loads return nothing, so give any trailing work time to finish
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_cfg(CFG_UNIFORM,  DATA_WIDTH'(uniform));
        write_cfg(CFG_VERTICES, DATA_WIDTH'(vertices));
        write_cfg(CFG_DLOW,     DATA_WIDTH'(lo));
        write_cfg(CFG_DHIGH,    DATA_WIDTH'(hi));
        write_cfg(CFG_SEGS,     DATA_WIDTH'(segs));
        cfg_valid <= 1'b0;
    endtask

    // Ascending positions spread over [lo, hi] for every entry in use.
    task automatic load_positions(longint lo, longint hi);
        int     n;
        longint step;
        n    = sb.last_entry() + 1;
        step = (hi - lo) / n;
        for (int k = 0; k < n; k++)
            send_item(CMD_LOAD, 8'(k), rand_between(lo + step * k, lo + step * k + step / 2),
                      rand_sample());
    endtask

    task automatic send_random_item();
        int                           pick;
        logic [7:0]                   idx;
        logic signed [DATA_WIDTH-1:0] coord;
        logic signed [DATA_WIDTH-1:0] sample;
        pick   = $urandom_range(99);
        idx    = 8'($urandom);
        coord  = $urandom;
        sample = rand_sample();
        if (pick < 4) begin
            send_item(CMD_LOAD, idx, coord, sample);
        end else if (pick < 14) begin
            // new value for an entry in use, position kept so the grid stays ordered
            idx = 8'($urandom_range(sb.last_entry()));
            send_item(CMD_LOAD, idx, sb.position_tbl[idx], sample);
        end else begin
            send_item(CMD_QUERY, idx, pick_coord(), sample);
        end
    endtask

    task automatic run_phase(int count, int sidle, int rstall, bit hold, bit pause);
        sender_idle_pct    = sidle;
        receiver_stall_pct = rstall;
        for (int k = 0; k < count; k++) begin
            if (hold && k == 5)
                hold_request = 1'b1;
            if (pause && k == count / 2)
                drain();
            send_random_item();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_UNIFORM;
        cfg_data  = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // write the whole table once, so no lookup ever touches an unset entry
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_item(CMD_LOAD, 8'(k), DATA_WIDTH'(longint'(k - 128) * 64'd8388608),
                      rand_sample());

        // extremes of index, position and value
        send_item(CMD_LOAD, 8'd0,   DMIN, DMIN);
        send_item(CMD_LOAD, 8'd1,   '0,   DMAX);
        send_item(CMD_LOAD, 8'd255, DMAX, 32'sd12345);

        // reset settings: below, at and above the domain, and interpolation inside it
        send_item(CMD_QUERY, 8'd0,   DMIN,         '0);
        send_item(CMD_QUERY, 8'd255, '0,           '0);
        send_item(CMD_QUERY, 8'd7,   32'sd1,       '0);
        send_item(CMD_QUERY, 8'd0,   32'sd32768,   DMAX);
        send_item(CMD_QUERY, 8'd0,   32'sd65535,   DMIN);
        send_item(CMD_QUERY, 8'd0,   32'sd65536,   '0);
        send_item(CMD_QUERY, 8'd0,   DMAX,         '0);

        apply_settings(1'b1, 1'b0, 0, ONE, 1);
        send_item(CMD_QUERY, 8'd0, 32'sd32768, '0);

        // stored positions: below all, beyond all, exactly on one, and between
        apply_settings(1'b0, 1'b1, DMIN, DMAX, 3);
        send_item(CMD_LOAD, 8'd0, -32'sd65536,  32'sd6553600);
        send_item(CMD_LOAD, 8'd1, '0,           -32'sd196608);
        send_item(CMD_LOAD, 8'd2, 32'sd65536,   DMAX);
        send_item(CMD_LOAD, 8'd3, 32'sd131072,  '0);
        send_item(CMD_QUERY, 8'd0, -32'sd131072, '0);
        send_item(CMD_QUERY, 8'd0, 32'sd300000,  '0);
        send_item(CMD_QUERY, 8'd0, '0,           '0);
        send_item(CMD_QUERY, 8'd0, 32'sd32768,   '0);
        send_item(CMD_QUERY, 8'd0, 32'sd100000,  '0);

        // zero segment count acts as one segment
        apply_settings(1'b1, 1'b1, 0, ONE, 0);
        send_item(CMD_QUERY, 8'd0, 32'sd20000, '0);

        // reversed domain
        apply_settings(1'b1, 1'b1, ONE, 0, 1);
        send_item(CMD_QUERY, 8'd0, 32'sd30000, '0);
        send_item(CMD_QUERY, 8'd0, 32'sd70000, '0);

        apply_settings(1'b1, 1'b1, -5 * ONE, 20 * ONE, 8);
        run_phase(35, 0, 0, 1'b1, 1'b0);

        apply_settings(1'b1, 1'b0, DMIN, DMAX, 255);
        run_phase(30, 68, 0, 1'b0, 1'b1);

        apply_settings(1'b0, 1'b1, -10 * ONE, 10 * ONE, 12);
        load_positions(-10 * ONE, 10 * ONE);
        run_phase(35, 0, 68, 1'b0, 1'b1);

        apply_settings(1'b0, 1'b0, DMIN, DMAX, 6);
        load_positions(DMIN, DMAX);
        run_phase(30, 21, 21, 1'b0, 1'b0);

        // full table on a stored-position grid: longest searches
        apply_settings(1'b0, 1'b1, DMIN, DMAX, 255);
        run_phase(20, 0, 0, 1'b0, 1'b0);

        apply_settings(1'b1, 1'b1, 3 * ONE, 3 * ONE, 0);
        run_phase(15, 68, 0, 1'b0, 1'b0);

        apply_settings(1'b1, 1'b1, 7 * ONE, -2 * ONE, 1);
        run_phase(15, 0, 68, 1'b0, 1'b0);

        // tiny span with many segments: coarse fractions
        apply_settings(1'b1, 1'b1, 0, 5, 200);
        run_phase(20, 21, 21, 1'b0, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
